/* src/pqdp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pqdp_pkg
// Shared types, constants and helpers for the packed quantized dot product.
// ----------------------------------------------------------------------------
package pqdp_pkg;

    // default parameter values
    localparam int ACT_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF = 48;

    // fixed geometry
    localparam int LANES      = 8;
    localparam int LANE_IDX_W = $clog2(LANES);
    localparam int Q_W        = 8;    // packed byte / widest field
    localparam int DIFF_W     = 18;   // (q << 8) - zero, signed
    localparam int ZERO_W     = 16;
    localparam int SCALE_W    = 24;
    localparam int MODE_W     = 2;
    localparam int OUT_W      = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET  = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'h010000;  // 1.0
    localparam logic [ZERO_W-1:0]  ZERO_RESET  = 16'h0000;

    typedef enum logic [MODE_W-1:0] {
        W8 = 2'd0,
        W4 = 2'd1,
        W2 = 2'd2,
        W1 = 2'd3
    } t_width_mode;

    // handoff from the merge stage to the scaler
    typedef struct packed {
        logic valid;
        logic ovf;
    } t_job_ctl;

    // field k of the packed byte, zero extended
    function automatic logic [Q_W-1:0] field_of(input logic [Q_W-1:0] b,
                                                input t_width_mode m,
                                                input int unsigned k);
        logic [Q_W-1:0] f;
        unique case (m)
            W8: f = b;
            W4: f = {4'b0, 4'(b >> (k * 4))};
            W2: f = {6'b0, 2'(b >> (k * 2))};
            W1: f = {7'b0, 1'(b >> k)};
            default: f = b;
        endcase
        return f;
    endfunction

    // index of the highest lane in use
    function automatic logic [LANE_IDX_W-1:0] last_lane(input t_width_mode m);
        logic [LANE_IDX_W-1:0] l;
        unique case (m)
            W8: l = LANE_IDX_W'(0);
            W4: l = LANE_IDX_W'(1);
            W2: l = LANE_IDX_W'(3);
            W1: l = LANE_IDX_W'(7);
            default: l = LANE_IDX_W'(0);
        endcase
        return l;
    endfunction

endpackage
`default_nettype wire

/* src/packed_quant_dot_product.sv */
`default_nettype none
// An item with n fields (n = 8/width) is multiplied in all lanes in its
// accept cycle and folded one lane per cycle; the next item is taken once the
// fold ends, or after a last item once the scaler takes the sum. The sum of a
// last beat passes a two-half scale multiply and round to the output register.
// Synchronous active-low reset clears registers to their defaults, the
// accumulator and flag to zero, and empties the output register.
// ----------------------------------------------------------------------------
// packed_quant_dot_product
// Dot product of sub-byte packed quantized weights with fixed-point
// activations: eight multiply lanes, a saturating merge and an output scaler.
// ----------------------------------------------------------------------------
module packed_quant_dot_product #(
    parameter int ACT_WIDTH = pqdp_pkg::ACT_WIDTH_DEF,
    parameter int ACC_WIDTH = pqdp_pkg::ACC_WIDTH_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration
    input  wire                                  i_cfg_wr_en,
    input  wire  [pqdp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [pqdp_pkg::CFG_DATA_W-1:0]      i_cfg_wr_data,
    // input channel
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire  [pqdp_pkg::Q_W-1:0]             i_packed_byte,
    input  wire  signed [ACT_WIDTH-1:0]          i_act_0,
    input  wire  signed [ACT_WIDTH-1:0]          i_act_1,
    input  wire  signed [ACT_WIDTH-1:0]          i_act_2,
    input  wire  signed [ACT_WIDTH-1:0]          i_act_3,
    input  wire  signed [ACT_WIDTH-1:0]          i_act_4,
    input  wire  signed [ACT_WIDTH-1:0]          i_act_5,
    input  wire  signed [ACT_WIDTH-1:0]          i_act_6,
    input  wire  signed [ACT_WIDTH-1:0]          i_act_7,
    input  wire                                  i_last,
    // output channel
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic signed [pqdp_pkg::OUT_W-1:0]    o_dot_result,
    output logic                                 o_saturated
);

    localparam int PW = pqdp_pkg::DIFF_W + ACT_WIDTH;

    pqdp_pkg::t_width_mode              r_width_mode;
    logic [pqdp_pkg::SCALE_W-1:0]       r_scale;
    logic [pqdp_pkg::ZERO_W-1:0]        r_zero;

    logic                               accept;
    logic                               merge_busy;
    logic                               scale_ready;
    pqdp_pkg::t_job_ctl                 job;
    logic [ACC_WIDTH-1:0]               acc;

    logic signed [ACT_WIDTH-1:0]        act [pqdp_pkg::LANES];
    logic [pqdp_pkg::LANES-1:0][PW-1:0] prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_mode <= pqdp_pkg::W8;
            r_scale      <= pqdp_pkg::SCALE_RESET;
            r_zero       <= pqdp_pkg::ZERO_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                pqdp_pkg::REG_WIDTH_MODE:
                    r_width_mode <= pqdp_pkg::t_width_mode'(
                                        i_cfg_wr_data[pqdp_pkg::MODE_W-1:0]);
                pqdp_pkg::REG_SCALE_FACTOR:
                    r_scale <= i_cfg_wr_data[pqdp_pkg::SCALE_W-1:0];
                pqdp_pkg::REG_ZERO_OFFSET:
                    r_zero <= i_cfg_wr_data[pqdp_pkg::ZERO_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign o_stall = merge_busy;
    assign accept  = i_valid && !merge_busy;

    assign act[0] = i_act_0;
    assign act[1] = i_act_1;
    assign act[2] = i_act_2;
    assign act[3] = i_act_3;
    assign act[4] = i_act_4;
    assign act[5] = i_act_5;
    assign act[6] = i_act_6;
    assign act[7] = i_act_7;

    for (genvar k = 0; k < pqdp_pkg::LANES; k++) begin : g_lane
        pqdp_lane #(
            .ACT_WIDTH (ACT_WIDTH)
        ) u_lane (
            .i_clk  (i_clk),
            .i_load (accept),
            .i_q    (pqdp_pkg::field_of(i_packed_byte, r_width_mode, k)),
            .i_zero (r_zero),
            .i_act  (act[k]),
            .o_prod (prod[k])
        );
    end

    pqdp_merge #(
        .ACT_WIDTH (ACT_WIDTH),
        .ACC_WIDTH (ACC_WIDTH)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (accept),
        .i_last        (i_last),
        .i_last_idx    (pqdp_pkg::last_lane(r_width_mode)),
        .i_prod        (prod),
        .i_scale_ready (scale_ready),
        .o_busy        (merge_busy),
        .o_job         (job),
        .o_acc         (acc)
    );

    pqdp_scale #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job),
        .i_acc        (acc),
        .i_scale      (r_scale),
        .o_ready      (scale_ready),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_dot_result (o_dot_result),
        .o_saturated  (o_saturated)
    );

endmodule
`default_nettype wire

/* src/pqdp_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pqdp_lane
// One lane: removes the zero point from a field and multiplies by its
// activation. The exact product (20 fraction bits) is registered.
// ----------------------------------------------------------------------------
module pqdp_lane #(
    parameter int ACT_WIDTH = pqdp_pkg::ACT_WIDTH_DEF
) (
    input  wire                                            i_clk,
    input  wire                                            i_load,
    input  wire  [pqdp_pkg::Q_W-1:0]                       i_q,
    input  wire  [pqdp_pkg::ZERO_W-1:0]                    i_zero,
    input  wire  signed [ACT_WIDTH-1:0]                    i_act,
    output logic signed [pqdp_pkg::DIFF_W+ACT_WIDTH-1:0]   o_prod
);

    localparam int PW = pqdp_pkg::DIFF_W + ACT_WIDTH;

    logic signed [pqdp_pkg::DIFF_W-1:0] diff;
    logic signed [PW-1:0]               n_prod;
    logic signed [PW-1:0]               r_prod;

    always_comb begin
        diff   = $signed({2'b00, i_q, 8'h00}) - $signed({2'b00, i_zero});
        n_prod = diff * i_act;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

/* src/pqdp_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pqdp_merge
// Saturating accumulator. Folds the lane products in lane order, one lane
// per cycle, and hands the sum to the scaler on the closing beat.
// ----------------------------------------------------------------------------
module pqdp_merge #(
    parameter int ACT_WIDTH = pqdp_pkg::ACT_WIDTH_DEF,
    parameter int ACC_WIDTH = pqdp_pkg::ACC_WIDTH_DEF
) (
    input  wire                                                  i_clk,
    input  wire                                                  i_rst_n,
    input  wire                                                  i_start,
    input  wire                                                  i_last,
    input  wire  [pqdp_pkg::LANE_IDX_W-1:0]                      i_last_idx,
    input  wire  [pqdp_pkg::LANES-1:0][pqdp_pkg::DIFF_W+ACT_WIDTH-1:0] i_prod,
    input  wire                                                  i_scale_ready,
    output logic                                                 o_busy,
    output pqdp_pkg::t_job_ctl                                   o_job,
    output logic [ACC_WIDTH-1:0]                                 o_acc
);

    localparam int PW = pqdp_pkg::DIFF_W + ACT_WIDTH;
    localparam int SW = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_HAND
    } t_state;

    t_state                              r_state;
    logic [pqdp_pkg::LANE_IDX_W-1:0]     r_idx;
    logic [pqdp_pkg::LANE_IDX_W-1:0]     r_last_idx;
    logic                                r_last;
    logic signed [ACC_WIDTH-1:0]         r_acc;
    logic                                r_ovf;

    logic signed [PW-1:0]                prod;
    logic signed [SW-1:0]                sum;
    logic signed [SW-1:0]                acc_max;
    logic signed [SW-1:0]                acc_min;
    logic signed [ACC_WIDTH-1:0]         n_acc;
    logic                                n_ovf;

    always_comb begin
        prod    = $signed(i_prod[r_idx]);
        acc_max = $signed({{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}});
        acc_min = $signed({{(SW-ACC_WIDTH+1){1'b1}}, {(ACC_WIDTH-1){1'b0}}});
        sum     = $signed({{(SW-ACC_WIDTH){r_acc[ACC_WIDTH-1]}}, r_acc})
                + $signed({{(SW-PW){prod[PW-1]}}, prod});
        n_ovf   = r_ovf;
        priority if (sum > acc_max) begin
            n_acc = acc_max[ACC_WIDTH-1:0];
            n_ovf = 1'b1;
        end else if (sum < acc_min) begin
            n_acc = acc_min[ACC_WIDTH-1:0];
            n_ovf = 1'b1;
        end else begin
            n_acc = sum[ACC_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_last_idx <= '0;
            r_last     <= 1'b0;
            r_acc      <= '0;
            r_ovf      <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state    <= S_ACC;
                        r_idx      <= '0;
                        r_last_idx <= i_last_idx;
                        r_last     <= i_last;
                    end
                end
                S_ACC: begin
                    r_acc <= n_acc;
                    r_ovf <= n_ovf;
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == r_last_idx) begin
                        r_state <= r_last ? S_HAND : S_IDLE;
                    end
                end
                S_HAND: begin
                    if (i_scale_ready) begin
                        r_acc   <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_job.valid = (r_state == S_HAND);
    assign o_job.ovf   = r_ovf;
    assign o_acc     = r_acc;

endmodule
`default_nettype wire

/* src/pqdp_scale.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pqdp_scale
// Output scaler: magnitude times scale in a low 32-bit half and a high half,
// round to nearest (ties away from zero), clamp to 32 bits, output register.
// ----------------------------------------------------------------------------
module pqdp_scale #(
    parameter int ACC_WIDTH = pqdp_pkg::ACC_WIDTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  pqdp_pkg::t_job_ctl                  i_job,
    input  wire  [ACC_WIDTH-1:0]                i_acc,
    input  wire  [pqdp_pkg::SCALE_W-1:0]        i_scale,
    output logic                                o_ready,
    input  wire                                 i_stall,
    output logic                                o_valid,
    output logic signed [pqdp_pkg::OUT_W-1:0]   o_dot_result,
    output logic                                o_saturated
);

    localparam int HW   = ACC_WIDTH - 32;
    localparam int HPW  = HW + pqdp_pkg::SCALE_W;
    localparam int LPW  = 32 + pqdp_pkg::SCALE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LO,
        S_HI,
        S_FIN
    } t_state;

    t_state                         r_state;
    logic                           r_neg;
    logic                           r_sat;
    logic [ACC_WIDTH-1:0]           r_mag;
    logic [LPW-1:0]                 r_lo_p;
    logic [HPW-1:0]                 r_hi_p;
    logic                           r_valid;
    logic [pqdp_pkg::OUT_W-1:0]     r_result;
    logic                           r_res_sat;

    logic [LPW:0]                   lo_rnd;
    logic [33:0]                    r_sum;
    logic [33:0]                    lim;
    logic                           hi_big;
    logic                           clamp;
    logic [pqdp_pkg::OUT_W-1:0]     mag_out;
    logic [pqdp_pkg::OUT_W-1:0]     n_result;

    assign o_ready = (r_state == S_IDLE) && (!r_valid || !i_stall);

    always_comb begin
        lo_rnd   = {1'b0, r_lo_p} + ((LPW+1)'(1) << 23);
        hi_big   = r_hi_p > (HPW'(1) << 24);
        r_sum    = {1'b0, r_hi_p[24:0], 8'h00} + {1'b0, lo_rnd[LPW:24]};
        lim      = r_neg ? 34'h080000000 : 34'h07FFFFFFF;
        clamp    = hi_big || (r_sum > lim);
        mag_out  = clamp ? lim[31:0] : r_sum[31:0];
        n_result = r_neg ? (32'h0 - mag_out) : mag_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job.valid && o_ready) begin
                        r_neg   <= i_acc[ACC_WIDTH-1];
                        r_mag   <= i_acc[ACC_WIDTH-1] ? (ACC_WIDTH'(0) - i_acc) : i_acc;
                        r_sat   <= i_job.ovf;
                        r_state <= S_LO;
                    end
                end
                S_LO: begin
                    r_lo_p  <= LPW'(r_mag[31:0] * i_scale);
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_hi_p  <= HPW'(r_mag[ACC_WIDTH-1:32] * i_scale);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_result  <= n_result;
                    r_res_sat <= r_sat || clamp;
                    r_valid   <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_dot_result = $signed(r_result);
    assign o_saturated  = r_res_sat;

endmodule
`default_nettype wire
